// ----- design/nts_pkg.sv -----
`default_nettype none

package nts_pkg;

    // Fixed field widths.
    localparam int COORD_W   = 24;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_W    = 16;
    localparam int CHAN_W    = 8;
    localparam int TEXEL_W   = 3 * CHAN_W;
    localparam int CFG_W     = 9;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    // Largest texture side and the widths that follow from it.
    localparam int MAX_SIZE = 256;
    localparam int IDX_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SIZE_W   = IDX_W + 1;
    localparam int SCALED_W = FRAC_BITS + 1 + SIZE_W;
    localparam int ADDR_CALC_W = (IDX_W + SIZE_W + 1 > ADDR_W) ? IDX_W + SIZE_W + 1 : ADDR_W;

    localparam logic [FRAC_BITS:0]   COORD_ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] COORD_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    // Number of register stages in the coordinate mapper.
    localparam int MAP_DEPTH = 3;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(256);

    // Register indexes.
    localparam logic CFG_TEX_WIDTH  = 1'b0;
    localparam logic CFG_TEX_HEIGHT = 1'b1;

    // Opcodes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic               valid;
        logic               write;
        logic [ADDR_W-1:0]  index;
        logic [TEXEL_W-1:0] texel;
    } t_ctl;

    typedef struct packed {
        logic               valid;
        logic               write;
        logic [ADDR_W-1:0]  index;
        logic [TEXEL_W-1:0] texel;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
    } t_mem_req;

    typedef struct packed {
        logic               valid;
        logic [TEXEL_W-1:0] texel;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
    } t_mem_rsp;

    // A zero size acts as one, a size above the maximum saturates.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (s == '0) begin
            r = SIZE_W'(1);
        end else if (int'(s) > MAX_SIZE) begin
            r = SIZE_W'(MAX_SIZE);
        end else begin
            r = SIZE_W'(s);
        end
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] to_byte(input logic [IDX_W-1:0] x);
        logic [IDX_W+CHAN_W-1:0] t;
        t = {{CHAN_W{1'b0}}, x};
        return t[CHAN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/nts_coord_map.sv -----
`default_nettype none

// Folds, scales and rounds one coordinate into a texel index over three stages.
module nts_coord_map (
    input  wire logic                              i_clk,
    input  wire logic signed [nts_pkg::COORD_W-1:0] i_coord,
    input  wire logic                              i_flip,
    input  wire logic [nts_pkg::SIZE_W-1:0]        i_size,
    output logic [nts_pkg::IDX_W-1:0]              o_index
);

    logic [nts_pkg::COORD_W-1:0]    w_abs;
    logic [nts_pkg::FRAC_BITS:0]    w_fold;
    logic [nts_pkg::FRAC_BITS:0]    n_folded;
    logic [nts_pkg::FRAC_BITS:0]    r_folded;
    logic [nts_pkg::SCALED_W-1:0]   n_scaled;
    logic [nts_pkg::SCALED_W-1:0]   r_scaled;
    logic [nts_pkg::SIZE_W:0]       w_ip;
    logic [nts_pkg::SIZE_W:0]       w_rounded;
    logic [nts_pkg::IDX_W-1:0]      n_index;
    logic [nts_pkg::IDX_W-1:0]      r_index;

    // Stage 1: absolute value, fold values above one back, optional flip.
    always_comb begin
        w_abs = i_coord[nts_pkg::COORD_W-1] ? (~i_coord + 1'b1) : i_coord;
        if (w_abs > nts_pkg::COORD_W'(nts_pkg::COORD_ONE)) begin
            w_fold = nts_pkg::COORD_ONE - {1'b0, w_abs[nts_pkg::FRAC_BITS-1:0]};
        end else begin
            w_fold = w_abs[nts_pkg::FRAC_BITS:0];
        end
        n_folded = i_flip ? (nts_pkg::COORD_ONE - w_fold) : w_fold;
    end

    // Stage 2: scale by the texture size.
    assign n_scaled = nts_pkg::SCALED_W'(r_folded) * nts_pkg::SCALED_W'(i_size);

    // Stage 3: round to nearest with an exact half going down, then wrap the size to zero.
    always_comb begin
        w_ip = r_scaled[nts_pkg::SCALED_W-1:nts_pkg::FRAC_BITS];
        if (r_scaled[nts_pkg::FRAC_BITS-1:0] > nts_pkg::COORD_HALF) begin
            w_rounded = w_ip + 1'b1;
        end else begin
            w_rounded = w_ip;
        end
        if (w_rounded == {1'b0, i_size}) begin
            n_index = '0;
        end else begin
            n_index = w_rounded[nts_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_folded <= n_folded;
        r_scaled <= n_scaled;
        r_index  <= n_index;
    end

    assign o_index = r_index;

endmodule

`default_nettype wire

// ----- design/nts_texel_mem.sv -----
`default_nettype none

// Address stage and texel store. Writes and reads meet the store in item order.
module nts_texel_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire nts_pkg::t_mem_req          i_req,
    input  wire logic [nts_pkg::SIZE_W-1:0] i_width,
    output nts_pkg::t_mem_rsp               o_rsp
);

    logic [nts_pkg::ADDR_CALC_W-1:0] w_addr_sum;
    nts_pkg::t_mem_req               r_a;
    logic [nts_pkg::ADDR_W-1:0]      n_addr;
    logic [nts_pkg::ADDR_W-1:0]      r_addr;
    logic                            r_b_valid;
    logic [nts_pkg::TEXEL_W-1:0]     r_rd;
    logic [nts_pkg::IDX_W-1:0]       r_b_col;
    logic [nts_pkg::IDX_W-1:0]       r_b_row;
    logic [nts_pkg::TEXEL_W-1:0]     r_store [nts_pkg::STORE_DEPTH];

    always_comb begin
        w_addr_sum = nts_pkg::ADDR_CALC_W'(i_req.row) * nts_pkg::ADDR_CALC_W'(i_width)
                   + nts_pkg::ADDR_CALC_W'(i_req.col);
        n_addr = i_req.write ? i_req.index : w_addr_sum[nts_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a.valid <= i_req.valid;
            r_b_valid <= r_a.valid && !r_a.write;
        end
        r_a.write <= i_req.write;
        r_a.index <= i_req.index;
        r_a.texel <= i_req.texel;
        r_a.col   <= i_req.col;
        r_a.row   <= i_req.row;
        r_addr    <= n_addr;
        r_b_col   <= r_a.col;
        r_b_row   <= r_a.row;
    end

    always_ff @(posedge i_clk) begin
        if (r_a.valid && r_a.write) begin
            r_store[r_addr] <= r_a.texel;
        end
        r_rd <= r_store[r_addr];
    end

    always_comb begin
        o_rsp.valid = r_b_valid;
        o_rsp.texel = r_rd;
        o_rsp.col   = r_b_col;
        o_rsp.row   = r_b_row;
    end

endmodule

`default_nettype wire

// ----- design/nearest_texel_sampler.sv -----
// Channel   | Direction | Signals                                        | Handshake
// ----------+-----------+------------------------------------------------+----------------------
// command   | in        | i_opcode, i_texel_index, i_red_in, i_green_in, | i_start && !o_busy
//           |           | i_blue_in, i_coord_u, i_coord_v                |
// result    | out       | o_red_out, o_green_out, o_blue_out,            | o_valid, one cycle
//           |           | o_texel_col, o_texel_row                       |
// config    | in        | i_cfg_index, i_cfg_data                        | i_cfg_we
//
// One item can be taken in every cycle; o_busy stays low.
// A sample item's result passes the coordinate mapper stages, the store address
// multiply-add register and the store read register before it shows.
// Write items reach the store at the store read stage, so a later sample sees them.
// Reset clears the pipeline valid bits and sets both sizes to 256; the store is not cleared.
// The receiver cannot stall; results are never held.
`default_nettype none

module nearest_texel_sampler (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic                                i_opcode,
    input  wire logic [nts_pkg::ADDR_W-1:0]          i_texel_index,
    input  wire logic [nts_pkg::CHAN_W-1:0]          i_red_in,
    input  wire logic [nts_pkg::CHAN_W-1:0]          i_green_in,
    input  wire logic [nts_pkg::CHAN_W-1:0]          i_blue_in,
    input  wire logic signed [nts_pkg::COORD_W-1:0]  i_coord_u,
    input  wire logic signed [nts_pkg::COORD_W-1:0]  i_coord_v,
    output logic                                     o_valid,
    output logic [nts_pkg::CHAN_W-1:0]               o_red_out,
    output logic [nts_pkg::CHAN_W-1:0]               o_green_out,
    output logic [nts_pkg::CHAN_W-1:0]               o_blue_out,
    output logic [nts_pkg::CHAN_W-1:0]               o_texel_col,
    output logic [nts_pkg::CHAN_W-1:0]               o_texel_row,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_index,
    input  wire logic [nts_pkg::CFG_W-1:0]           i_cfg_data
);

    logic                          w_accept;
    logic [nts_pkg::CFG_W-1:0]     r_tex_width;
    logic [nts_pkg::CFG_W-1:0]     r_tex_height;
    logic [nts_pkg::SIZE_W-1:0]    w_width;
    logic [nts_pkg::SIZE_W-1:0]    w_height;
    nts_pkg::t_ctl                 n_ctl;
    nts_pkg::t_ctl                 r_ctl [nts_pkg::MAP_DEPTH];
    logic [nts_pkg::IDX_W-1:0]     w_col;
    logic [nts_pkg::IDX_W-1:0]     w_row;
    nts_pkg::t_mem_req             w_req;
    nts_pkg::t_mem_rsp             w_rsp;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= nts_pkg::CFG_SIZE_RESET;
            r_tex_height <= nts_pkg::CFG_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nts_pkg::CFG_TEX_WIDTH:  r_tex_width  <= i_cfg_data;
                nts_pkg::CFG_TEX_HEIGHT: r_tex_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_width  = nts_pkg::clamp_size(r_tex_width);
    assign w_height = nts_pkg::clamp_size(r_tex_height);

    always_comb begin
        n_ctl.valid = w_accept;
        n_ctl.write = (i_opcode == nts_pkg::OP_WRITE);
        n_ctl.index = i_texel_index;
        n_ctl.texel = {i_red_in, i_green_in, i_blue_in};
    end

    // Item control travels beside the coordinate mappers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < nts_pkg::MAP_DEPTH; i++) begin
                r_ctl[i].valid <= 1'b0;
            end
        end else begin
            r_ctl[0].valid <= n_ctl.valid;
            for (int i = 1; i < nts_pkg::MAP_DEPTH; i++) begin
                r_ctl[i].valid <= r_ctl[i-1].valid;
            end
        end
        r_ctl[0].write <= n_ctl.write;
        r_ctl[0].index <= n_ctl.index;
        r_ctl[0].texel <= n_ctl.texel;
        for (int i = 1; i < nts_pkg::MAP_DEPTH; i++) begin
            r_ctl[i].write <= r_ctl[i-1].write;
            r_ctl[i].index <= r_ctl[i-1].index;
            r_ctl[i].texel <= r_ctl[i-1].texel;
        end
    end

    nts_coord_map u_map_u (
        .i_clk   (i_clk),
        .i_coord (i_coord_u),
        .i_flip  (1'b0),
        .i_size  (w_width),
        .o_index (w_col)
    );

    nts_coord_map u_map_v (
        .i_clk   (i_clk),
        .i_coord (i_coord_v),
        .i_flip  (1'b1),
        .i_size  (w_height),
        .o_index (w_row)
    );

    always_comb begin
        w_req.valid = r_ctl[nts_pkg::MAP_DEPTH-1].valid;
        w_req.write = r_ctl[nts_pkg::MAP_DEPTH-1].write;
        w_req.index = r_ctl[nts_pkg::MAP_DEPTH-1].index;
        w_req.texel = r_ctl[nts_pkg::MAP_DEPTH-1].texel;
        w_req.col   = w_col;
        w_req.row   = w_row;
    end

    nts_texel_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_width (w_width),
        .o_rsp   (w_rsp)
    );

    assign o_valid     = w_rsp.valid;
    assign o_red_out   = w_rsp.texel[3*nts_pkg::CHAN_W-1:2*nts_pkg::CHAN_W];
    assign o_green_out = w_rsp.texel[2*nts_pkg::CHAN_W-1:nts_pkg::CHAN_W];
    assign o_blue_out  = w_rsp.texel[nts_pkg::CHAN_W-1:0];
    assign o_texel_col = nts_pkg::to_byte(w_rsp.col);
    assign o_texel_row = nts_pkg::to_byte(w_rsp.row);

    // Every sample item, and nothing else, gives a result.
    a_result_per_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
            && $past(i_rst_n, 4) && $past(i_rst_n, 5))
        |-> (o_valid == $past(w_accept && (i_opcode == nts_pkg::OP_SAMPLE), 5)))
        else $error("result strobe does not match sample items taken");

    // A u of zero or of plus or minus one lands in column zero.
    a_col_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
            && $past(i_rst_n, 4) && $past(i_rst_n, 5)
            && $past(w_accept && (i_opcode == nts_pkg::OP_SAMPLE)
                && ((i_coord_u == '0)
                    || (i_coord_u == nts_pkg::COORD_W'(nts_pkg::COORD_ONE))
                    || (i_coord_u == -nts_pkg::COORD_W'(nts_pkg::COORD_ONE))), 5))
        |-> (o_texel_col == '0))
        else $error("edge u coordinate did not map to column zero");

    // A v of zero or one lands in row zero after the flip and wrap.
    a_row_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
            && $past(i_rst_n, 4) && $past(i_rst_n, 5)
            && $past(w_accept && (i_opcode == nts_pkg::OP_SAMPLE)
                && ((i_coord_v == '0)
                    || (i_coord_v == nts_pkg::COORD_W'(nts_pkg::COORD_ONE))), 5))
        |-> (o_texel_row == '0))
        else $error("edge v coordinate did not map to row zero");

endmodule

`default_nettype wire

// ----- tb/nearest_texel_sampler_tb.sv -----
`timescale 1ns / 100ps

module nearest_texel_sampler_tb;

    localparam int CLK_HALF = 5;
    // Covers the mapper and store stages between an accepted item and its result, plus some margin.
    localparam int DRAIN_CYCLES = nts_pkg::MAP_DEPTH + 2 + 3;
    localparam longint unsigned ONE_Q = 64'd1 << nts_pkg::FRAC_BITS;

    typedef struct packed {
        logic [nts_pkg::CHAN_W-1:0] red;
        logic [nts_pkg::CHAN_W-1:0] green;
        logic [nts_pkg::CHAN_W-1:0] blue;
        logic [nts_pkg::CHAN_W-1:0] col;
        logic [nts_pkg::CHAN_W-1:0] row;
    } t_texel_result;

    typedef struct {
        logic                        op;
        logic [nts_pkg::ADDR_W-1:0]  index;
        logic [nts_pkg::TEXEL_W-1:0] texel;
        logic [nts_pkg::COORD_W-1:0] u;
        logic [nts_pkg::COORD_W-1:0] v;
        bit                          typed;
        t_texel_result               want;
    } t_directed_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_start;
    logic                         o_busy;
    logic                         i_opcode;
    logic [nts_pkg::ADDR_W-1:0]   i_texel_index;
    logic [nts_pkg::CHAN_W-1:0]   i_red_in;
    logic [nts_pkg::CHAN_W-1:0]   i_green_in;
    logic [nts_pkg::CHAN_W-1:0]   i_blue_in;
    logic [nts_pkg::COORD_W-1:0]  i_coord_u;
    logic [nts_pkg::COORD_W-1:0]  i_coord_v;
    logic                         o_valid;
    logic [nts_pkg::CHAN_W-1:0]   o_red_out;
    logic [nts_pkg::CHAN_W-1:0]   o_green_out;
    logic [nts_pkg::CHAN_W-1:0]   o_blue_out;
    logic [nts_pkg::CHAN_W-1:0]   o_texel_col;
    logic [nts_pkg::CHAN_W-1:0]   o_texel_row;
    logic                         i_cfg_we;
    logic                         i_cfg_index;
    logic [nts_pkg::CFG_W-1:0]    i_cfg_data;

    // Local copy of the texture and of the size registers.
    logic [nts_pkg::TEXEL_W-1:0]  shadow_texels [nts_pkg::STORE_DEPTH];
    bit                           texel_written [nts_pkg::STORE_DEPTH];
    logic [nts_pkg::CFG_W-1:0]    width_reg;
    logic [nts_pkg::CFG_W-1:0]    height_reg;

    t_texel_result       pending_texels [$];
    t_directed_row       directed_rows [$];

    int err_count;
    int samples_checked;
    int samples_sent;
    int writes_sent;
    int size_settings;

    nearest_texel_sampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_opcode      (i_opcode),
        .i_texel_index (i_texel_index),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_coord_u     (i_coord_u),
        .i_coord_v     (i_coord_v),
        .o_valid       (o_valid),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_texel_col   (o_texel_col),
        .o_texel_row   (o_texel_row),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic int unsigned eff_size(input logic [nts_pkg::CFG_W-1:0] s);
        if (s == '0) begin
            return 1;
        end
        if (int'(s) > nts_pkg::MAX_SIZE) begin
            return nts_pkg::MAX_SIZE;
        end
        return int'(s);
    endfunction

    // Fold a coordinate into [0,1], optionally flip it, scale and round with
    // an exact half going down, then wrap a result equal to the size.
    function automatic int unsigned map_coord(input logic [nts_pkg::COORD_W-1:0] raw,
                                              input int unsigned size, input bit flip);
        longint unsigned mag;
        longint unsigned scaled;
        longint unsigned pick;
        mag = 64'(raw);
        if (raw[nts_pkg::COORD_W-1]) begin
            mag = (64'd1 << nts_pkg::COORD_W) - mag;
        end
        if (mag > ONE_Q) begin
            mag = ONE_Q - (mag & (ONE_Q - 1));
        end
        if (flip) begin
            mag = ONE_Q - mag;
        end
        scaled = mag * 64'(size);
        pick = scaled >> nts_pkg::FRAC_BITS;
        if ((scaled & (ONE_Q - 1)) > (ONE_Q >> 1)) begin
            pick++;
        end
        return int'(pick % 64'(size));
    endfunction

    function automatic logic [nts_pkg::ADDR_W-1:0] sample_addr(
        input logic [nts_pkg::COORD_W-1:0] u,
        input logic [nts_pkg::COORD_W-1:0] v);
        int unsigned w;
        w = eff_size(width_reg);
        return nts_pkg::ADDR_W'(map_coord(v, eff_size(height_reg), 1'b1) * w
                                + map_coord(u, w, 1'b0));
    endfunction

    function automatic t_texel_result sample_texel(input logic [nts_pkg::COORD_W-1:0] u,
                                                   input logic [nts_pkg::COORD_W-1:0] v);
        t_texel_result r;
        logic [nts_pkg::TEXEL_W-1:0] t;
        t = shadow_texels[sample_addr(u, v)];
        r.red   = t[nts_pkg::TEXEL_W-1 -: nts_pkg::CHAN_W];
        r.green = t[2*nts_pkg::CHAN_W-1 -: nts_pkg::CHAN_W];
        r.blue  = t[nts_pkg::CHAN_W-1:0];
        r.col   = nts_pkg::CHAN_W'(map_coord(u, eff_size(width_reg), 1'b0));
        r.row   = nts_pkg::CHAN_W'(map_coord(v, eff_size(height_reg), 1'b1));
        return r;
    endfunction

    function automatic logic [nts_pkg::COORD_W-1:0] rand_coord(input int unsigned size);
        longint c;
        longint k;
        k = longint'($urandom_range(0, size - 1));
        case ($urandom_range(0, 5))
            0: c = longint'($urandom);
            1: c = longint'($urandom_range(0, 2 * ONE_Q)) - longint'(ONE_Q);
            // Right at a rounding tie for power-of-two sizes, or one step off.
            2: c = ((2 * k + 1) << (nts_pkg::FRAC_BITS - 1)) / longint'(size)
                   + longint'($urandom_range(0, 2)) - 1;
            3: c = (longint'($urandom_range(0, 254)) - 127) << nts_pkg::FRAC_BITS;
            4: c = (k << nts_pkg::FRAC_BITS) / longint'(size);
            default: c = longint'(ONE_Q) + longint'($urandom_range(0, 6)) - 3;
        endcase
        if ($urandom_range(0, 1) == 1) begin
            c = -c;
        end
        return c[nts_pkg::COORD_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [nts_pkg::CHAN_W-1:0] got,
                               input logic [nts_pkg::CHAN_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %02h, expected %02h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_texel_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_texels.size() == 0) begin
                report_mismatch("result with no sample item outstanding");
            end else begin
                want = pending_texels.pop_front();
                samples_checked++;
                check_field("red", o_red_out, want.red);
                check_field("green", o_green_out, want.green);
                check_field("blue", o_blue_out, want.blue);
                check_field("col", o_texel_col, want.col);
                check_field("row", o_texel_row, want.row);
            end
        end
    end

    task automatic send_item(input logic op, input logic [nts_pkg::ADDR_W-1:0] index,
                             input logic [nts_pkg::TEXEL_W-1:0] texel,
                             input logic [nts_pkg::COORD_W-1:0] u,
                             input logic [nts_pkg::COORD_W-1:0] v,
                             input bit typed, input t_texel_result want);
        @(negedge i_clk);
        i_opcode      = op;
        i_texel_index = index;
        i_red_in      = texel[nts_pkg::TEXEL_W-1 -: nts_pkg::CHAN_W];
        i_green_in    = texel[2*nts_pkg::CHAN_W-1 -: nts_pkg::CHAN_W];
        i_blue_in     = texel[nts_pkg::CHAN_W-1:0];
        i_coord_u     = u;
        i_coord_v     = v;
        i_start       = 1'b1;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        if (op == nts_pkg::OP_WRITE) begin
            shadow_texels[index] = texel;
            texel_written[index] = 1'b1;
            writes_sent++;
        end else begin
            pending_texels.push_back(typed ? want : sample_texel(u, v));
            samples_sent++;
        end
    endtask

    // A sample may only land on a texel that holds data, so a write to that
    // texel goes first when needed.
    task automatic send_sample(input logic [nts_pkg::COORD_W-1:0] u,
                               input logic [nts_pkg::COORD_W-1:0] v,
                               input bit typed, input t_texel_result want);
        logic [nts_pkg::ADDR_W-1:0] addr;
        addr = sample_addr(u, v);
        if (!texel_written[addr]) begin
            send_item(nts_pkg::OP_WRITE, addr, nts_pkg::TEXEL_W'($urandom),
                      rand_coord(nts_pkg::MAX_SIZE), rand_coord(nts_pkg::MAX_SIZE),
                      1'b0, '0);
        end
        send_item(nts_pkg::OP_SAMPLE, nts_pkg::ADDR_W'($urandom),
                  nts_pkg::TEXEL_W'($urandom), u, v, typed, want);
    endtask

    task automatic idle_burst(input int unsigned cycles);
        @(negedge i_clk);
        i_start = 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic set_sizes(input logic [nts_pkg::CFG_W-1:0] w,
                             input logic [nts_pkg::CFG_W-1:0] h);
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_texels.size() != 0) @(posedge i_clk);
        // Write items still in flight must reach the store first.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = nts_pkg::CFG_TEX_WIDTH;
        i_cfg_data  = w;
        @(negedge i_clk);
        i_cfg_index = nts_pkg::CFG_TEX_HEIGHT;
        i_cfg_data  = h;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        width_reg   = w;
        height_reg  = h;
        size_settings++;
    endtask

    // Texel writes that a sample needs first count toward the phase.
    task automatic run_phase(input int n_items, input bit allow_idle);
        int unsigned w;
        int unsigned h;
        int sent_at_start;
        logic [nts_pkg::ADDR_W-1:0] idx;
        w = eff_size(width_reg);
        h = eff_size(height_reg);
        sent_at_start = samples_sent + writes_sent;
        while (samples_sent + writes_sent - sent_at_start < n_items) begin
            if (allow_idle && $urandom_range(0, 7) == 0) begin
                idle_burst($urandom_range(1, 17));
            end
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    idx = nts_pkg::ADDR_W'($urandom);
                end else begin
                    idx = nts_pkg::ADDR_W'($urandom_range(0, w * h - 1));
                end
                send_item(nts_pkg::OP_WRITE, idx, nts_pkg::TEXEL_W'($urandom),
                          rand_coord(w), rand_coord(h), 1'b0, '0);
            end else begin
                send_sample(rand_coord(w), rand_coord(h), 1'b0, '0);
            end
        end
    endtask

    task automatic add_row(input logic op, input logic [nts_pkg::ADDR_W-1:0] index,
                           input logic [nts_pkg::TEXEL_W-1:0] texel,
                           input logic [nts_pkg::COORD_W-1:0] u,
                           input logic [nts_pkg::COORD_W-1:0] v,
                           input bit typed, input t_texel_result want);
        t_directed_row r;
        r.op    = op;
        r.index = index;
        r.texel = texel;
        r.u     = u;
        r.v     = v;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    initial begin : stimulus
        int waited;
        t_directed_row r;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_opcode      = nts_pkg::OP_WRITE;
        i_texel_index = '0;
        i_red_in      = '0;
        i_green_in    = '0;
        i_blue_in     = '0;
        i_coord_u     = '0;
        i_coord_v     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = nts_pkg::CFG_TEX_WIDTH;
        i_cfg_data    = '0;
        width_reg     = nts_pkg::CFG_SIZE_RESET;
        height_reg    = nts_pkg::CFG_SIZE_RESET;
        err_count       = 0;
        samples_checked = 0;
        samples_sent    = 0;
        writes_sent     = 0;
        size_settings   = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items run at the reset size of 256 x 256.
        // Expected results are {red, green, blue, col, row}.
        add_row(nts_pkg::OP_WRITE, 16'h0000, 24'hFF0000, '0, '0, 1'b0, '0);
        add_row(nts_pkg::OP_WRITE, 16'hFFFF, 24'h00FF00, '0, '0, 1'b0, '0);
        add_row(nts_pkg::OP_WRITE, 16'h0001, 24'h0000FF, '0, '0, 1'b0, '0);
        add_row(nts_pkg::OP_WRITE, 16'h0080, 24'hA55A3C, '0, '0, 1'b0, '0);
        // u of zero, and v of exactly one flipped to row zero.
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h000000, 24'h010000, 1'b1,
                {8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        // u of exactly one wraps to column zero; v of zero flips to one and wraps.
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h010000, 24'h000000, 1'b1,
                {8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'hFF0000, 24'hFF0000, 1'b1,
                {8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h00FF00, 24'h000100, 1'b1,
                {8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF});
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'hFF0100, 24'hFFFF00, 1'b1,
                {8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF});
        // Whole numbers above one have no fraction and act as one.
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h030000, 24'h050000, 1'b1,
                {8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        // Exactly half a texel rounds down, just above it rounds up.
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h000080, 24'h010000, 1'b1,
                {8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h000081, 24'h010000, 1'b1,
                {8'h00, 8'h00, 8'hFF, 8'h01, 8'h00});
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h008000, 24'h010000, 1'b1,
                {8'hA5, 8'h5A, 8'h3C, 8'h80, 8'h00});
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h7FFFFF, 24'h7FFFFF, 1'b0, '0);
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h800000, 24'h800000, 1'b0, '0);
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h014000, 24'h014000, 1'b0, '0);
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'hFFFFFF, 24'h000001, 1'b0, '0);
        add_row(nts_pkg::OP_WRITE, 16'h5555, 24'h55AA55, '0, '0, 1'b0, '0);
        add_row(nts_pkg::OP_WRITE, 16'hAAAA, 24'hAA55AA, '0, '0, 1'b0, '0);
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h005500, 24'h00AB00, 1'b1,
                {8'h55, 8'hAA, 8'h55, 8'h55, 8'h55});
        add_row(nts_pkg::OP_SAMPLE, '0, '0, 24'h00AA00, 24'h005600, 1'b1,
                {8'hAA, 8'h55, 8'hAA, 8'hAA, 8'hAA});

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.op == nts_pkg::OP_WRITE) begin
                send_item(nts_pkg::OP_WRITE, r.index, r.texel, r.u, r.v, 1'b0, '0);
            end else begin
                send_sample(r.u, r.v, r.typed, r.want);
            end
        end

        // Random phases at several sizes; zero sizes act as one and oversized ones saturate.
        set_sizes(9'd1, 9'd1);
        run_phase(150, 1'b1);
        set_sizes(9'd0, 9'd0);
        run_phase(100, 1'b1);
        set_sizes(9'd511, 9'd300);
        run_phase(200, 1'b1);
        set_sizes(9'd256, 9'd1);
        run_phase(150, 1'b1);
        set_sizes(9'd1, 9'd256);
        run_phase(150, 1'b1);
        set_sizes(9'd3, 9'd5);
        run_phase(200, 1'b1);
        set_sizes(9'd17, 9'd200);
        run_phase(200, 1'b1);
        set_sizes(9'd2, 9'd2);
        run_phase(100, 1'b1);
        set_sizes(nts_pkg::CFG_W'($urandom_range(1, 256)),
                  nts_pkg::CFG_W'($urandom_range(1, 256)));
        run_phase(200, 1'b1);
        set_sizes(nts_pkg::CFG_W'($urandom_range(1, 256)),
                  nts_pkg::CFG_W'($urandom_range(1, 256)));
        run_phase(200, 1'b1);
        set_sizes(9'd256, 9'd256);
        run_phase(220, 1'b0);

        @(negedge i_clk);
        i_start = 1'b0;
        waited = 0;
        while (pending_texels.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_texels.size() != 0) begin
            report_mismatch($sformatf("%0d sample items never produced a result",
                                      pending_texels.size()));
            pending_texels.delete();
        end

        $display("Checked %0d of %0d sample items, %0d texel writes, %0d size settings.",
                 samples_checked, samples_sent, writes_sent, size_settings);
        $display("Covered rounding ties, folds above one, wraps, sizes 0 to 511; %0d errors.",
                 err_count);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
